[rtl/xsfb_pkg.sv]
package xsfb_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  localparam int unsigned LineBits   = 64;  // width of one frame line
  localparam int unsigned SpriteBits = 8;   // pixels in one sprite row
  localparam int unsigned LineIdxW   = 6;   // enough for up to 64 lines
  localparam int unsigned DimW       = 7;   // holds a screen size up to 64

  // Decoded request, passed from the decoder to the update control.
  typedef struct packed {
    req_e                  kind;
    logic [LineIdxW-1:0]   line;
    logic                  line_ok;
    logic [LineBits-1:0]   mask;
    logic                  first_row;
    logic                  last_row;
  } req_t;

  // Remainder of an 8-bit value by a modulus of at least 8, by five
  // restoring compare and subtract steps (the quotient never exceeds 31).
  function automatic logic [DimW-1:0] mod_small(input logic [7:0] val,
                                                input logic [DimW-1:0] m);
    logic [11:0] r;
    logic [11:0] d;
    r = {4'b0, val};
    for (int s = 4; s >= 0; s--) begin
      d = {5'b0, m} << s;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[DimW-1:0];
  endfunction

endpackage

[rtl/xsfb_ram.sv]
module xsfb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/xsfb_decode.sv]
module xsfb_decode #(
  parameter int unsigned ScreenWidth  = 64,
  parameter int unsigned ScreenHeight = 32
) (
  input  logic [1:0]   req_type_i,
  input  logic [7:0]   x_pos_i,
  input  logic [7:0]   y_pos_i,
  input  logic [3:0]   row_index_i,
  input  logic [7:0]   row_bits_i,
  input  logic         last_row_i,
  input  logic [4:0]   read_line_i,
  output xsfb_pkg::req_t req_o
);

  localparam logic [xsfb_pkg::DimW-1:0] WidthC  = xsfb_pkg::DimW'(ScreenWidth);
  localparam logic [xsfb_pkg::DimW-1:0] HeightC = xsfb_pkg::DimW'(ScreenHeight);
  // Columns that exist on the screen, column 0 in the top bit.
  localparam logic [xsfb_pkg::LineBits-1:0] LineMask =
      ~({xsfb_pkg::LineBits{1'b1}} >> ScreenWidth);

  logic [xsfb_pkg::DimW-1:0]     col0;
  logic [xsfb_pkg::DimW-1:0]     y_mod;
  logic [xsfb_pkg::DimW:0]       draw_line;
  logic [xsfb_pkg::LineBits-1:0] placed;
  xsfb_pkg::req_e                kind;

  assign kind  = xsfb_pkg::req_e'(req_type_i);
  assign col0  = xsfb_pkg::mod_small(x_pos_i, WidthC);
  assign y_mod = xsfb_pkg::mod_small(y_pos_i, HeightC);
  assign draw_line = {1'b0, y_mod} + {4'b0, row_index_i};

  // Sprite pixels shifted out past bit 0 or past the right edge are dropped.
  assign placed = {row_bits_i, {(xsfb_pkg::LineBits - xsfb_pkg::SpriteBits){1'b0}}} >> col0;

  always_comb begin
    req_o           = '0;
    req_o.kind      = kind;
    req_o.mask      = placed & LineMask;
    req_o.first_row = (row_index_i == 4'd0);
    req_o.last_row  = last_row_i;
    if (kind == xsfb_pkg::REQ_READ) begin
      req_o.line    = xsfb_pkg::LineIdxW'(read_line_i);
      req_o.line_ok = ({2'b0, read_line_i} < HeightC);
    end else begin
      req_o.line    = draw_line[xsfb_pkg::LineIdxW-1:0];
      req_o.line_ok = (draw_line < {1'b0, HeightC});
    end
  end

endmodule

[rtl/xor_sprite_framebuffer.sv]
// One-bit framebuffer for a CHIP-8 style display, SCREEN_WIDTH by SCREEN_HEIGHT
// pixels, one 64-bit line per memory word with column 0 in bit 63. Each input
// word is a clear, a draw of one 8-pixel sprite row (XOR onto the screen, with
// origin wrapped modulo the screen size and pixels past the right or bottom
// edge clipped), or a read of one line; every input word yields exactly one
// output word. For a draw and a read, the line is read from the frame memory
// in the cycle the word is accepted, and modified, written back and reported
// in the next. No new word is taken during that update cycle, so the block
// takes no other word until the read-modify-write of one line is through.
// A clear and an unused request code complete in the accept cycle. A stalled
// output word holds off the input until it is taken. The collision
// flag clears on sprite row 0 and accumulates whenever a set sprite bit lands
// on a lit pixel; it is reported with every draw together with an echo of
// last_row. Reset and clear act at once through one valid flag per line, so
// there is no clearing pass and the block accepts words from the first cycle
// after reset.
module xor_sprite_framebuffer #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic [3:0]  row_index_i,
  input  logic [7:0]  row_bits_i,
  input  logic        last_row_i,
  input  logic [4:0]  read_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        collision_o,
  output logic [63:0] line_data_o,
  output logic        sprite_done_o
);

  localparam int unsigned AddrW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  xsfb_pkg::req_t   dec_req;
  xsfb_pkg::req_t   req_q;
  xsfb_pkg::state_e state_q, state_d;

  logic [SCREEN_HEIGHT-1:0] line_valid_q, line_valid_d;
  logic                     hit_q, hit_d;
  logic                     out_valid_q, out_valid_d;
  logic                     collision_q, collision_d;
  logic [63:0]              line_data_q, line_data_d;
  logic                     sprite_done_q, sprite_done_d;
  logic                     out_load;

  logic             accept;
  logic             mem_re;
  logic             mem_we;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] upd_addr;
  logic [63:0]      mem_rdata;
  logic [63:0]      cur_line;
  logic [63:0]      new_line;
  logic             hit_base;

  xsfb_decode #(
    .ScreenWidth  (SCREEN_WIDTH),
    .ScreenHeight (SCREEN_HEIGHT)
  ) u_decode (
    .req_type_i  (req_type_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .last_row_i  (last_row_i),
    .read_line_i (read_line_i),
    .req_o       (dec_req)
  );

  // A new word is taken only when the update stage is free and the output
  // register is empty or is being emptied in this cycle.
  assign in_stall_o = (state_q != xsfb_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_addr  = dec_req.line[AddrW-1:0];
  assign upd_addr = req_q.line[AddrW-1:0];
  assign mem_re   = accept && ((dec_req.kind == xsfb_pkg::REQ_DRAW) ||
                               (dec_req.kind == xsfb_pkg::REQ_READ));

  xsfb_ram #(
    .Width (64),
    .Depth (SCREEN_HEIGHT)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (upd_addr),
    .wdata_i (new_line),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  // A line that has not been written since reset or the last clear reads as
  // dark. The write-back of one word always lands before the next word's read.
  assign cur_line = (req_q.line_ok && line_valid_q[upd_addr]) ? mem_rdata : '0;
  assign new_line = cur_line ^ req_q.mask;
  assign hit_base = req_q.first_row ? 1'b0 : hit_q;

  always_comb begin
    state_d       = state_q;
    line_valid_d  = line_valid_q;
    hit_d         = hit_q;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    collision_d   = 1'b0;
    line_data_d   = '0;
    sprite_done_d = 1'b0;

    unique case (state_q)
      xsfb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (dec_req.kind)
            xsfb_pkg::REQ_CLEAR: begin
              line_valid_d = '0;
              out_load     = 1'b1;
            end
            xsfb_pkg::REQ_DRAW, xsfb_pkg::REQ_READ: begin
              state_d = xsfb_pkg::ST_UPDATE;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      xsfb_pkg::ST_UPDATE: begin
        out_load = 1'b1;
        state_d  = xsfb_pkg::ST_IDLE;
        if (req_q.kind == xsfb_pkg::REQ_DRAW) begin
          hit_d = hit_base | (req_q.line_ok && ((cur_line & req_q.mask) != '0));
          if (req_q.line_ok) begin
            mem_we                 = 1'b1;
            line_valid_d[upd_addr] = 1'b1;
          end
          collision_d   = hit_d;
          sprite_done_d = req_q.last_row;
        end else begin
          line_data_d = cur_line;
        end
      end
      default: begin
        state_d = xsfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= xsfb_pkg::ST_IDLE;
      line_valid_q <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_valid_q <= line_valid_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: request held for the update cycle, result word held
  // until the output side takes it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= dec_req;
    end
    if (out_load) begin
      collision_q   <= collision_d;
      line_data_q   <= line_data_d;
      sprite_done_q <= sprite_done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign collision_o   = collision_q;
  assign line_data_o   = line_data_q;
  assign sprite_done_o = sprite_done_q;

endmodule
